### rtl/core/spq_pkg.sv
// spq_pkg: types and constants shared by the sorted priority queue files.
// No dependencies.

package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic                     enq;   // accepted enqueue with room
        logic                     deq;   // accepted dequeue on a non-empty queue
        logic [PRIO_W-1:0]        prio;  // priority of the incoming item
        logic signed [DATA_W-1:0] data;  // data word of the incoming item
    } cell_ctrl_t;

endpackage

### rtl/core/spq_req_if.sv
// spq_req_if: request channel of the sorted priority queue.
// Depends on spq_pkg.

interface spq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [spq_pkg::DATA_W-1:0] data_in;
    logic [spq_pkg::PRIO_W-1:0]        prio_in;

    modport source (output valid, req_type, data_in, prio_in, input ready);
    modport sink   (input valid, req_type, data_in, prio_in, output ready);
endinterface

### rtl/core/spq_rsp_if.sv
// spq_rsp_if: response channel of the sorted priority queue.
// Depends on spq_pkg.

interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [spq_pkg::DATA_W-1:0] data_out;
    logic [spq_pkg::STAT_W-1:0]        status;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, data_out, status, occupancy, input ready);
    modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

### rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted chain; holds a data word and its priority.
// Shifts toward the tail on insert, toward the head on removal.
// Depends on spq_pkg.

module spq_cell (
    input  logic                              clk,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic                              valid,
    input  logic                              left_open,
    input  logic signed [spq_pkg::DATA_W-1:0] left_data,
    input  logic [spq_pkg::PRIO_W-1:0]        left_prio,
    input  logic signed [spq_pkg::DATA_W-1:0] right_data,
    input  logic [spq_pkg::PRIO_W-1:0]        right_prio,
    output logic                              open,
    output logic signed [spq_pkg::DATA_W-1:0] data,
    output logic [spq_pkg::PRIO_W-1:0]        prio
);

    logic signed [spq_pkg::DATA_W-1:0] data_reg, data_next;
    logic [spq_pkg::PRIO_W-1:0]        prio_reg, prio_next;

    // Slot is empty or holds a strictly larger priority: new item goes at or before it.
    assign open = !valid || (prio_reg > ctrl.prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.enq)
        begin
            if (left_open)
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
            else if (open)
            begin
                data_next = ctrl.data;
                prio_next = ctrl.prio;
            end
        end
        else if (ctrl.deq)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

### rtl/core/sorted_priority_queue_top.sv
// sorted_priority_queue_top: bounded priority queue as a chain of sorted cells.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
//
// Usage:
//   req channel: req_type selects enqueue (data_in, prio_in) or dequeue.
//   rsp channel: one item per request with data_out, status and occupancy.
//   Status: enqueued, full (refused, queue unchanged), dequeued, or empty.
//   Entries leave in ascending priority; equal priorities leave in arrival order.
// Timing:
//   Every request is handled by all cells at once; on enqueue each cell compares its
//   priority with the incoming one, and cells from the insertion point on shift by one slot.
//   The response is registered and is valid in the cycle after the request is taken.
//   Throughput is 1 item per cycle while rsp.ready is high: a new request is taken
//   in the same cycle the output register is emptied or while it is empty.
// Stall:
//   While the receiver holds rsp.ready low with a response pending, req.ready
//   is low and the queue holds its contents.
// Reset:
//   rst_n clears the entry count and the response valid; the queue starts empty.
//   Cell contents are not reset; slots past the count are never read.

module sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic signed [spq_pkg::DATA_W-1:0] rsp_data_reg, rsp_data_next;
    logic [spq_pkg::STAT_W-1:0]        rsp_stat_reg, rsp_stat_next;
    logic [spq_pkg::OCC_W-1:0]         rsp_occ_reg, rsp_occ_next;

    logic accept;
    logic is_deq;
    logic full;
    logic empty;
    spq_pkg::cell_ctrl_t ctrl;

    logic                              open_q [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0] data_q [DEPTH];
    logic [spq_pkg::PRIO_W-1:0]        prio_q [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_deq    = (req.req_type == spq_pkg::REQ_DEQ);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign ctrl.enq  = accept && !is_deq && !full;
    assign ctrl.deq  = accept && is_deq && !empty;
    assign ctrl.prio = req.prio_in;
    assign ctrl.data = req.data_in;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                              l_open;
        logic signed [spq_pkg::DATA_W-1:0] l_data;
        logic [spq_pkg::PRIO_W-1:0]        l_prio;
        logic signed [spq_pkg::DATA_W-1:0] r_data;
        logic [spq_pkg::PRIO_W-1:0]        r_prio;

        if (i == 0)
        begin : g_head
            assign l_open = 1'b0;
            assign l_data = req.data_in;
            assign l_prio = req.prio_in;
        end
        else
        begin : g_mid
            assign l_open = open_q[i-1];
            assign l_data = data_q[i-1];
            assign l_prio = prio_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_data = data_q[i];
            assign r_prio = prio_q[i];
        end
        else
        begin : g_inner
            assign r_data = data_q[i+1];
            assign r_prio = prio_q[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (CNT_W'(i) < count_reg),
            .left_open  (l_open),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .right_data (r_data),
            .right_prio (r_prio),
            .open       (open_q[i]),
            .data       (data_q[i]),
            .prio       (prio_q[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_stat_next  = rsp_stat_reg;
        rsp_occ_next   = rsp_occ_reg;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = '0;
            if (ctrl.enq)
            begin
                count_next    = count_reg + CNT_W'(1);
                rsp_stat_next = spq_pkg::ST_ENQ;
            end
            else if (ctrl.deq)
            begin
                count_next    = count_reg - CNT_W'(1);
                rsp_data_next = data_q[0];
                rsp_stat_next = spq_pkg::ST_DEQ;
            end
            else if (is_deq)
                rsp_stat_next = spq_pkg::ST_EMPTY;
            else
                rsp_stat_next = spq_pkg::ST_FULL;
            rsp_occ_next = spq_pkg::OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        rsp_stat_reg <= rsp_stat_next;
        rsp_occ_reg  <= rsp_occ_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.data_out  = rsp_data_reg;
    assign rsp.status    = rsp_stat_reg;
    assign rsp.occupancy = rsp_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without an accepted item");

    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_deq && empty) |=>
            (rsp.valid && rsp.status == spq_pkg::ST_EMPTY && rsp.data_out == '0))
        else $error("dequeue on empty queue gave wrong response");

    a_full_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_deq && full) |=>
            (rsp.valid && rsp.status == spq_pkg::ST_FULL && $stable(count_reg)))
        else $error("enqueue on full queue gave wrong response");

endmodule
